FILE: rtl/core/sfpe_pkg.sv
`default_nettype none

package sfpe_pkg;

    // field widths
    localparam int unsigned ADDR_W = 24;
    localparam int unsigned BYTE_W = 8;

    // default geometry
    localparam int unsigned PAGE_BYTES_DEF  = 256;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // configuration port
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [1:0] REG_WREN  = 2'd0;
    localparam logic [1:0] REG_PROG  = 2'd1;
    localparam logic [1:0] REG_ERASE = 2'd2;

    localparam logic [BYTE_W-1:0] WREN_RESET  = 8'd6;
    localparam logic [BYTE_W-1:0] PROG_RESET  = 8'd2;
    localparam logic [BYTE_W-1:0] ERASE_RESET = 8'd32;

    // byte positions inside one queued job
    localparam logic [2:0] STEP_WREN   = 3'd0;
    localparam logic [2:0] STEP_OPCODE = 3'd1;
    localparam logic [2:0] STEP_ADDR_H = 3'd2;
    localparam logic [2:0] STEP_ADDR_M = 3'd3;
    localparam logic [2:0] STEP_ADDR_L = 3'd4;
    localparam logic [2:0] STEP_DATA   = 3'd5;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] spi_byte;
        logic              frame_end;
        logic              wait_ready;
        logic              last;
    } t_out_item;

    // what the back end has to send for one accepted transaction
    typedef enum logic [1:0] {
        KIND_ERASE,
        KIND_PROG,
        KIND_DATA
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              fend;
    } t_job;

    typedef struct packed {
        logic [BYTE_W-1:0] wren;
        logic [BYTE_W-1:0] prog;
        logic [BYTE_W-1:0] erase;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/core/sfpe_front.sv
`default_nettype none

module sfpe_front #(
    parameter int unsigned PAGE_BYTES = sfpe_pkg::PAGE_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire sfpe_pkg::t_in_item i_item,
    output logic                  o_stall,
    output logic                  o_push,
    output sfpe_pkg::t_job        o_job,
    input  wire logic             i_full
);
    import sfpe_pkg::*;

    localparam int unsigned OFF_W  = $clog2(PAGE_BYTES);
    localparam int unsigned PAGE_W = $clog2(PAGE_BYTES + 1);
    localparam int unsigned SHIFT  = ADDR_W + OFF_W;
    localparam int unsigned MUL_W  = ADDR_W + 1;
    localparam int unsigned PROD_W = ADDR_W + MUL_W;
    localparam longint unsigned MUL_L =
        ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    localparam logic [MUL_W-1:0]  MUL_K  = MUL_W'(MUL_L);
    localparam logic [PAGE_W-1:0] PAGE_K = PAGE_W'(PAGE_BYTES);
    localparam logic [OFF_W-1:0]  OFF_LAST = OFF_W'(PAGE_BYTES - 1);

    // pipeline and classifier state
    logic              r_v1, r_v2;
    t_in_item          r_it1, r_it2;
    logic [ADDR_W-1:0] r_q1;
    logic [OFF_W-1:0]  r_rem2;
    logic              r_open, n_open;
    logic [ADDR_W-1:0] r_next_addr, n_next_addr;
    logic [OFF_W-1:0]  r_off, n_off;

    logic [PROD_W-1:0] w_prod, w_quot;
    logic [ADDR_W-1:0] w_back, w_rem_full;
    logic              w_adv, w_drop;
    t_kind             w_kind;
    logic [ADDR_W-1:0] w_cur_addr, w_follow;
    logic [OFF_W-1:0]  w_cur_off;
    logic              w_page_end;

    // quotient by reciprocal multiply, exact for 24-bit addresses
    assign w_prod = PROD_W'(i_item.address) * PROD_W'(MUL_K);
    assign w_quot = w_prod >> SHIFT;

    // remainder from the registered quotient
    assign w_back     = ADDR_W'(r_q1 * PAGE_K);
    assign w_rem_full = r_it1.address - w_back;

    // classify the transaction in stage two
    always_comb begin
        w_drop      = 1'b0;
        w_kind      = KIND_DATA;
        w_cur_addr  = r_next_addr;
        w_cur_off   = r_off;
        n_open      = r_open;
        if (r_it2.action) begin
            w_kind     = KIND_ERASE;
            w_cur_addr = r_it2.address;
            w_drop     = r_open;
        end else if (!r_open) begin
            w_kind     = KIND_PROG;
            w_cur_addr = r_it2.address;
            w_cur_off  = r_rem2;
            w_drop     = !r_it2.first_byte;
            n_open     = !r_it2.last_byte;
        end else begin
            w_kind = (r_off == '0) ? KIND_PROG : KIND_DATA;
            n_open = !r_it2.last_byte;
        end
        w_follow    = w_cur_addr + ADDR_W'(1);
        w_page_end  = (w_follow == '0) || (w_cur_off == OFF_LAST);
        n_next_addr = w_follow;
        n_off       = w_page_end ? '0 : w_cur_off + OFF_W'(1);
    end

    assign w_adv   = !r_v2 || w_drop || !i_full;
    assign o_stall = !w_adv;
    assign o_push  = r_v2 && !w_drop && !i_full;

    always_comb begin
        o_job.kind = w_kind;
        o_job.addr = w_cur_addr;
        o_job.data = r_it2.data_byte;
        o_job.fend = r_it2.last_byte || w_page_end;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_open      <= 1'b0;
            r_next_addr <= '0;
            r_off       <= '0;
        end else begin
            if (w_adv) begin
                r_v1 <= i_valid;
                r_v2 <= r_v1;
            end
            if (r_v2 && w_adv && !w_drop && !r_it2.action) begin
                r_open      <= n_open;
                r_next_addr <= n_next_addr;
                r_off       <= n_off;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_it1  <= i_item;
            r_q1   <= w_quot[ADDR_W-1:0];
            r_it2  <= r_it1;
            r_rem2 <= w_rem_full[OFF_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sfpe_queue.sv
`default_nettype none

module sfpe_queue #(
    parameter int unsigned DEPTH = sfpe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire sfpe_pkg::t_job i_job,
    output logic             o_full,
    output logic             o_head_valid,
    output sfpe_pkg::t_job   o_head,
    input  wire logic        i_pop
);
    import sfpe_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push, w_pop;

    assign o_full       = (r_cnt == CNT_W'(DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_pop && o_head_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sfpe_back.sv
`default_nettype none

module sfpe_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sfpe_pkg::t_cfg i_cfg,
    input  wire logic          i_head_valid,
    input  wire sfpe_pkg::t_job i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    output sfpe_pkg::t_out_item o_out_item,
    input  wire logic          i_out_stall
);
    import sfpe_pkg::*;

    logic [2:0] r_idx, n_idx;
    logic [2:0] w_step;
    logic       w_emit;
    t_out_item  w_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    assign w_emit = i_head_valid && (!r_out_valid || !i_out_stall);
    assign w_step = (i_head.kind == KIND_DATA) ? STEP_DATA : r_idx;

    // byte select for the current job
    always_comb begin
        w_item = '0;
        unique case (w_step)
            STEP_WREN: begin
                w_item.spi_byte  = i_cfg.wren;
                w_item.frame_end = 1'b1;
            end
            STEP_OPCODE: begin
                w_item.spi_byte = (i_head.kind == KIND_ERASE) ? i_cfg.erase : i_cfg.prog;
            end
            STEP_ADDR_H: w_item.spi_byte = i_head.addr[23:16];
            STEP_ADDR_M: w_item.spi_byte = i_head.addr[15:8];
            STEP_ADDR_L: begin
                w_item.spi_byte   = i_head.addr[7:0];
                w_item.frame_end  = (i_head.kind == KIND_ERASE);
                w_item.wait_ready = (i_head.kind == KIND_ERASE);
                w_item.last       = (i_head.kind == KIND_ERASE);
            end
            STEP_DATA: begin
                w_item.spi_byte   = i_head.data;
                w_item.frame_end  = i_head.fend;
                w_item.wait_ready = i_head.fend;
                w_item.last       = 1'b1;
            end
            default: w_item = '0;
        endcase
    end

    assign o_pop = w_emit && w_item.last;
    assign n_idx = w_item.last ? STEP_WREN : r_idx + 3'd1;

    // step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= STEP_WREN;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_idx       <= n_idx;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_item <= w_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

FILE: rtl/core/spi_flash_program_erase_framer.sv
`default_nettype none

// Turns write bytes and sector-erase requests into SPI NOR command frames, one
// result per SPI byte. A data byte inside an open page gives one output byte, so
// a write streams at one byte per clock unless the output stall or a full job
// queue holds it. A transaction that opens a page gives six bytes (write enable,
// program opcode, three address bytes, data) and an erase gives five; the output
// register sends one byte per clock unless stalled; the queue takes input until
// full. Input passes through two classifier stages (page offset by a
// reciprocal multiply), the job queue, then the output register. Stray data
// bytes and erases during an open write give no output. There is no clearing
// pass after reset. Registers sit at byte addresses 0, 4 and 8 (write enable,
// program, erase opcodes) and should be written only while the block is idle.
module spi_flash_program_erase_framer #(
    parameter int unsigned PAGE_BYTES  = sfpe_pkg::PAGE_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH = sfpe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire sfpe_pkg::t_in_item                i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output sfpe_pkg::t_out_item                    o_out_item,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sfpe_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [sfpe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sfpe_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import sfpe_pkg::*;

    t_cfg  r_cfg;
    logic  w_cfg_wr;
    logic  w_push, w_full, w_head_valid, w_pop;
    t_job  w_job, w_head;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wren  <= WREN_RESET;
            r_cfg.prog  <= PROG_RESET;
            r_cfg.erase <= ERASE_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_WREN:  r_cfg.wren  <= pwdata[BYTE_W-1:0];
                REG_PROG:  r_cfg.prog  <= pwdata[BYTE_W-1:0];
                REG_ERASE: r_cfg.erase <= pwdata[BYTE_W-1:0];
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WREN:  prdata = APB_DATA_W'(r_cfg.wren);
            REG_PROG:  prdata = APB_DATA_W'(r_cfg.prog);
            REG_ERASE: prdata = APB_DATA_W'(r_cfg.erase);
            default:   prdata = '0;
        endcase
    end

    // front: accept and classify
    sfpe_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .o_push  (w_push),
        .o_job   (w_job),
        .i_full  (w_full)
    );

    // job queue between front and back
    sfpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_job        (w_job),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // back: expand jobs into spi bytes
    sfpe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_stall  (i_out_stall)
    );

`ifndef NO_ASSERTIONS
    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("job pushed into full queue");

    // a frame closed without a ready wait is the write-enable frame
    a_wren_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.frame_end && !o_out_item.wait_ready)
            |-> !o_out_item.last)
        else $error("write-enable frame marked last");

    // a ready wait always closes the frame
    a_wait_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.wait_ready) |-> o_out_item.frame_end)
        else $error("wait_ready without frame_end");

    // the queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !w_head_valid)
        else $error("queue not empty after reset");
`endif

endmodule

`default_nettype wire
